// ----- design/rotation_matrix_to_quaternion_defines.svh -----
// Assertion macros used by the queue of the rotation matrix to quaternion design.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RMQ_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RMQ_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rmq_pkg.sv -----
// Shared types and constants for the rotation matrix to quaternion block.
package rmq_pkg;

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_DIAG0 = 2'd1,
        BR_DIAG1 = 2'd2,
        BR_DIAG2 = 2'd3
    } branch_t;

    // Output slots of the quaternion parts.
    localparam logic [1:0] SLOT_X = 2'd0;
    localparam logic [1:0] SLOT_Y = 2'd1;
    localparam logic [1:0] SLOT_Z = 2'd2;
    localparam logic [1:0] SLOT_W = 2'd3;

    typedef struct packed {
        branch_t    branch;
        logic       invalid;
        logic [1:0] root_slot;
    } ctl_t;

    localparam int CTL_W = $bits(ctl_t);

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

endpackage

// ----- design/rmq_front.sv -----
// Front end: takes a matrix beat, picks the branch and forms root argument and lanes.
module rmq_front #(
    parameter int E = 20,
    parameter int F = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [E-1:0]     m00,
    input  logic signed [E-1:0]     m01,
    input  logic signed [E-1:0]     m02,
    input  logic signed [E-1:0]     m10,
    input  logic signed [E-1:0]     m11,
    input  logic signed [E-1:0]     m12,
    input  logic signed [E-1:0]     m20,
    input  logic signed [E-1:0]     m21,
    input  logic signed [E-1:0]     m22,
    output logic                    fr_valid,
    input  logic                    fr_ready,
    output rmq_pkg::ctl_t           fr_ctl,
    output logic [((E > F) ? E : F)+1:0] fr_arg,
    output logic [3*(E+1)-1:0]      fr_lanes
);
    import rmq_pkg::*;

    localparam int AW = ((E > F) ? E : F) + 3;
    localparam int DW = E + 1;
    localparam logic signed [AW-1:0] ONE_Q = AW'(1) <<< F;

    logic signed [AW-1:0] e00, e11, e22, tr, arg_s;
    logic signed [DW-1:0] d01, d02, d10, d12, d20, d21;
    logic                 pos, sel1, sel2, neg;
    logic signed [AW-1:0] mii;
    ctl_t                 ctl_c;
    logic signed [DW-1:0] l0, l1, l2;

    logic                 valid_reg;
    ctl_t                 ctl_reg;
    logic [AW-2:0]        arg_reg;
    logic [3*DW-1:0]      lanes_reg;

    // Diagonal extended to the argument width, off-diagonals to the lane width.
    assign e00 = AW'(m00);
    assign e11 = AW'(m11);
    assign e22 = AW'(m22);
    assign d01 = DW'(m01);
    assign d02 = DW'(m02);
    assign d10 = DW'(m10);
    assign d12 = DW'(m12);
    assign d20 = DW'(m20);
    assign d21 = DW'(m21);

    // Trace test and largest diagonal search; ties keep the lower index.
    assign tr   = e00 + e11 + e22;
    assign pos  = tr > 0;
    assign sel1 = e11 > e00;
    assign mii  = sel1 ? e11 : e00;
    assign sel2 = e22 > mii;

    // Root argument and the three divided lanes for each branch.
    always_comb
    begin
        ctl_c.invalid = 1'b0;
        if (pos)
        begin
            ctl_c.branch    = BR_TRACE;
            ctl_c.root_slot = SLOT_W;
            arg_s = tr + ONE_Q;
            l0 = d12 - d21;
            l1 = d20 - d02;
            l2 = d01 - d10;
        end
        else if (sel2)
        begin
            ctl_c.branch    = BR_DIAG2;
            ctl_c.root_slot = SLOT_Z;
            arg_s = e22 - (e00 + e11) + ONE_Q;
            l0 = d20 + d02;
            l1 = d21 + d12;
            l2 = d01 - d10;
        end
        else if (sel1)
        begin
            ctl_c.branch    = BR_DIAG1;
            ctl_c.root_slot = SLOT_Y;
            arg_s = e11 - (e22 + e00) + ONE_Q;
            l0 = d10 + d01;
            l1 = d12 + d21;
            l2 = d20 - d02;
        end
        else
        begin
            ctl_c.branch    = BR_DIAG0;
            ctl_c.root_slot = SLOT_X;
            arg_s = e00 - (e11 + e22) + ONE_Q;
            l0 = d01 + d10;
            l1 = d02 + d20;
            l2 = d12 - d21;
        end
        neg = arg_s[AW-1];
        if (neg)
        begin
            ctl_c.invalid = 1'b1;
        end
    end

    // Holding register towards the queue.
    assign full = valid_reg && !fr_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!full)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!full && push)
        begin
            ctl_reg   <= ctl_c;
            arg_reg   <= neg ? '0 : arg_s[AW-2:0];
            lanes_reg <= {l2, l1, l0};
        end
    end

    assign fr_valid = valid_reg;
    assign fr_ctl   = ctl_reg;
    assign fr_arg   = arg_reg;
    assign fr_lanes = lanes_reg;

endmodule

// ----- design/rmq_queue.sv -----
// Short queue that decouples the front end from the arithmetic pipeline.
`include "rotation_matrix_to_quaternion_defines.svh"
module rmq_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rdata
);
    import rmq_pkg::*;

    logic [W-1:0]    mem [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]   cnt_reg;
    logic            push_ok, pop_ok;

    assign full    = cnt_reg == (Q_AW+1)'(Q_DEPTH);
    assign empty   = cnt_reg == '0;
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push_ok)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_ok)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_ok && !pop_ok)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop_ok && !push_ok)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    `RMQ_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= (Q_AW+1)'(Q_DEPTH), "queue overfilled")
    `RMQ_ASSERT_NXT(a_cnt_up, clk, rst_n, push_ok && !pop_ok, cnt_reg == $past(cnt_reg) + 1'b1, "count did not rise")
    `RMQ_ASSERT_NXT(a_cnt_dn, clk, rst_n, pop_ok && !push_ok, cnt_reg == $past(cnt_reg) - 1'b1, "count did not fall")

endmodule

// ----- design/rmq_back.sv -----
// Back end: pipelined square root, three pipelined dividers and the output register.
module rmq_back #(
    parameter int E = 20,
    parameter int F = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_pop,
    input  rmq_pkg::ctl_t           in_ctl,
    input  logic [((E > F) ? E : F)+1:0] in_arg,
    input  logic [3*(E+1)-1:0]      in_lanes,
    input  logic                    pop,
    output logic                    empty,
    output logic signed [E-1:0]     qx,
    output logic signed [E-1:0]     qy,
    output logic signed [E-1:0]     qz,
    output logic signed [E-1:0]     qw,
    output logic [1:0]              branch,
    output logic                    invalid
);
    import rmq_pkg::*;

    localparam int AW  = ((E > F) ? E : F) + 3;
    localparam int DW  = E + 1;
    localparam int RW  = (AW + F) / 2;
    localparam int RDW = 2 * RW;
    localparam int RMW = RW + 3;
    localparam int N   = E + 1 + F;
    localparam int PS  = RW + N;
    localparam int XW  = ((RW > N) ? RW : N) + 2;
    localparam logic [XW-1:0] MAX_X = XW'((64'd1 << (E - 1)) - 64'd1);
    localparam logic [XW-1:0] MIN_X = XW'(64'd1 << (E - 1));

    typedef struct packed {
        ctl_t                  ctl;
        logic [RDW-1:0]        rad;
        logic [RMW-1:0]        rem;
        logic [RW-1:0]         root;
        logic [2:0]            neg;
        logic [2:0][N-1:0]     num;
        logic [2:0][RMW-1:0]   drem;
        logic [2:0][N-1:0]     quot;
    } stage_t;

    stage_t          src [PS];
    stage_t          stg_next [PS];
    stage_t          stg_reg [PS];
    logic            vld_reg [PS];
    stage_t          head;
    stage_t          fin;
    logic            en;

    logic                   out_valid_reg;
    logic signed [E-1:0]    q_reg [4];
    logic [1:0]             branch_reg;
    logic                   invalid_reg;
    logic signed [E-1:0]    lane_res [3];
    logic signed [E-1:0]    root_res;
    logic signed [E-1:0]    slot_res [4];

    // The whole pipeline moves unless a finished beat waits at the output.
    assign en     = !out_valid_reg || pop;
    assign in_pop = en && in_valid;

    // Loading of a new beat: radicand is the argument scaled by the fraction.
    always_comb
    begin
        logic signed [DW-1:0] d;
        logic [DW-1:0]        mag;
        head       = '0;
        head.ctl   = in_ctl;
        head.rad   = RDW'({in_arg, {F{1'b0}}});
        for (int l = 0; l < 3; l++)
        begin
            d   = in_lanes[l*DW +: DW];
            mag = d[DW-1] ? DW'(-d) : DW'(d);
            head.neg[l] = d[DW-1];
            head.num[l] = {mag, {F{1'b0}}};
        end
    end

    // One root bit per stage, then one quotient bit per stage for each lane.
    always_comb
    begin
        logic [RMW-1:0] remsh, trial, rsh, den;
        logic [RW-1:0]  rootsh;
        src[0] = head;
        for (int s = 1; s < PS; s++)
        begin
            src[s] = stg_reg[s-1];
        end
        for (int s = 0; s < PS; s++)
        begin
            stg_next[s] = src[s];
            if (s < RW)
            begin
                remsh  = {src[s].rem[RMW-3:0], src[s].rad[RDW-1:RDW-2]};
                rootsh = {src[s].root[RW-2:0], 1'b0};
                trial  = RMW'({rootsh, 1'b1});
                stg_next[s].rad = src[s].rad << 2;
                if (remsh >= trial)
                begin
                    stg_next[s].rem  = remsh - trial;
                    stg_next[s].root = rootsh | RW'(1);
                end
                else
                begin
                    stg_next[s].rem  = remsh;
                    stg_next[s].root = rootsh;
                end
            end
            else
            begin
                den = RMW'({src[s].root, 1'b0});
                for (int l = 0; l < 3; l++)
                begin
                    rsh = {src[s].drem[l][RMW-2:0], src[s].num[l][N-1]};
                    stg_next[s].num[l] = src[s].num[l] << 1;
                    if (rsh >= den)
                    begin
                        stg_next[s].drem[l] = rsh - den;
                        stg_next[s].quot[l] = {src[s].quot[l][N-2:0], 1'b1};
                    end
                    else
                    begin
                        stg_next[s].drem[l] = rsh;
                        stg_next[s].quot[l] = {src[s].quot[l][N-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < PS; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < PS; s++)
            begin
                stg_reg[s] <= stg_next[s];
            end
        end
    end

    // Saturation of the root half and the signed quotients.
    assign fin = stg_reg[PS-1];

    always_comb
    begin
        logic [XW-1:0] half, qv;
        half     = XW'(fin.root >> 1);
        root_res = (half > MAX_X) ? MAX_X[E-1:0] : half[E-1:0];
        for (int l = 0; l < 3; l++)
        begin
            qv = XW'(fin.quot[l]);
            if (fin.root == '0)
            begin
                lane_res[l] = '0;
            end
            else if (fin.neg[l])
            begin
                lane_res[l] = (qv > MIN_X) ? MIN_X[E-1:0] : E'(-qv);
            end
            else
            begin
                lane_res[l] = (qv > MAX_X) ? MAX_X[E-1:0] : qv[E-1:0];
            end
        end
    end

    // Lanes fill the slots other than the root slot in ascending order.
    always_comb
    begin
        for (int s = 0; s < 4; s++)
        begin
            if (2'(s) == fin.ctl.root_slot)
            begin
                slot_res[s] = root_res;
            end
            else if (2'(s) < fin.ctl.root_slot)
            begin
                slot_res[s] = lane_res[s];
            end
            else
            begin
                slot_res[s] = lane_res[s-1];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_reg[PS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[PS-1])
        begin
            for (int s = 0; s < 4; s++)
            begin
                q_reg[s] <= slot_res[s];
            end
            branch_reg  <= fin.ctl.branch;
            invalid_reg <= fin.ctl.invalid;
        end
    end

    assign empty   = !out_valid_reg;
    assign qx      = q_reg[SLOT_X];
    assign qy      = q_reg[SLOT_Y];
    assign qz      = q_reg[SLOT_Z];
    assign qw      = q_reg[SLOT_W];
    assign branch  = branch_reg;
    assign invalid = invalid_reg;

endmodule

// ----- design/rotation_matrix_to_quaternion.sv -----
// Top level of the rotation matrix to quaternion converter.
//
// Input channel: push/full. A matrix beat (m00..m22, signed, FRAC_BITS
// fraction bits) is taken at a clock edge with push high and full low.
// Result channel: empty/pop. While empty is low the oldest result (qx, qy,
// qz, qw, branch, invalid) is on the ports; pop high at an edge takes it.
// One matrix can be taken every cycle while full is low, and one result
// leaves every cycle while pop is high and results are ready. The root has
// RW = (AW + FRAC_BITS) / 2 bits, AW = max(ELEM_WIDTH, FRAC_BITS) + 3, and
// each quotient N = ELEM_WIDTH + FRAC_BITS + 1 bits. A matrix passes the
// front register, the queue, the square root pipeline (one root bit per
// stage), the divider pipelines (one quotient bit per stage) and the output
// register. When the receiver stalls the arithmetic pipeline holds, the
// four-entry queue behind the front end fills, and full rises once it and
// the front register are occupied. Reset empties every stage and the queue.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS  = 16,
    parameter int ELEM_WIDTH = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic signed [ELEM_WIDTH-1:0] m00,
    input  logic signed [ELEM_WIDTH-1:0] m01,
    input  logic signed [ELEM_WIDTH-1:0] m02,
    input  logic signed [ELEM_WIDTH-1:0] m10,
    input  logic signed [ELEM_WIDTH-1:0] m11,
    input  logic signed [ELEM_WIDTH-1:0] m12,
    input  logic signed [ELEM_WIDTH-1:0] m20,
    input  logic signed [ELEM_WIDTH-1:0] m21,
    input  logic signed [ELEM_WIDTH-1:0] m22,
    input  logic                         pop,
    output logic                         empty,
    output logic signed [ELEM_WIDTH-1:0] qx,
    output logic signed [ELEM_WIDTH-1:0] qy,
    output logic signed [ELEM_WIDTH-1:0] qz,
    output logic signed [ELEM_WIDTH-1:0] qw,
    output logic [1:0]                   branch,
    output logic                         invalid
);
    import rmq_pkg::*;

    localparam int AW = ((ELEM_WIDTH > FRAC_BITS) ? ELEM_WIDTH : FRAC_BITS) + 3;
    localparam int DW = ELEM_WIDTH + 1;
    localparam int QW = CTL_W + (AW - 1) + 3 * DW;

    logic            fr_valid, q_full, q_empty, q_pop;
    ctl_t            fr_ctl, bk_ctl;
    logic [AW-2:0]   fr_arg, bk_arg;
    logic [3*DW-1:0] fr_lanes, bk_lanes;
    logic [QW-1:0]   q_rdata;

    // Classification of incoming beats.
    rmq_front #(.E(ELEM_WIDTH), .F(FRAC_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .m00      (m00),
        .m01      (m01),
        .m02      (m02),
        .m10      (m10),
        .m11      (m11),
        .m12      (m12),
        .m20      (m20),
        .m21      (m21),
        .m22      (m22),
        .fr_valid (fr_valid),
        .fr_ready (!q_full),
        .fr_ctl   (fr_ctl),
        .fr_arg   (fr_arg),
        .fr_lanes (fr_lanes)
    );

    // Decoupling queue.
    rmq_queue #(.W(QW)) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_valid),
        .full  (q_full),
        .wdata ({fr_ctl, fr_arg, fr_lanes}),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_rdata)
    );

    assign {bk_ctl, bk_arg, bk_lanes} = q_rdata;

    // Root, division and result register.
    rmq_back #(.E(ELEM_WIDTH), .F(FRAC_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!q_empty),
        .in_pop   (q_pop),
        .in_ctl   (bk_ctl),
        .in_arg   (bk_arg),
        .in_lanes (bk_lanes),
        .pop      (pop),
        .empty    (empty),
        .qx       (qx),
        .qy       (qy),
        .qz       (qz),
        .qw       (qw),
        .branch   (branch),
        .invalid  (invalid)
    );

endmodule

// ----- tb/rotation_matrix_to_quaternion_tb.sv -----
// Testbench for the rotation matrix to quaternion converter: directed and random matrices.
module rotation_matrix_to_quaternion_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmq_pkg::*;

    localparam int FB = 16;
    localparam int EW = 20;
    localparam longint MAXP = (64'sd1 <<< (EW - 1)) - 1;
    localparam longint MINN = -MAXP - 1;
    localparam longint ONE = 64'sd1 <<< FB;
    localparam int LATENCY = 58;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef logic signed [EW-1:0] elem_t;

    typedef struct {
        elem_t   qx;
        elem_t   qy;
        elem_t   qz;
        elem_t   qw;
        branch_t br;
        logic    bad;
    } quat_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  push = 1'b0;
    logic  pop = 1'b0;
    elem_t m00 = '0, m01 = '0, m02 = '0, m10 = '0, m11 = '0;
    elem_t m12 = '0, m20 = '0, m21 = '0, m22 = '0;
    logic  full, empty, invalid;
    elem_t qx, qy, qz, qw;
    logic [1:0] branch;

    quat_t quat_fifo[$];
    int    mismatches = 0;
    int    beats_in = 0;
    int    beats_out = 0;
    int    idle_cycles = 0;
    int    rx_idle_pct = 24;
    int    tx_idle_pct = 24;
    int    rx_hold = 0;
    int    branch_seen[4] = '{0, 0, 0, 0};
    int    clamped_seen = 0;

    rotation_matrix_to_quaternion u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22), .pop(pop), .empty(empty),
        .qx(qx), .qy(qy), .qz(qz), .qw(qw), .branch(branch), .invalid(invalid)
    );

    always #5 clk = ~clk;

    // Floor square root of a non-negative value by bit-serial restoring method.
    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scaled quotient d / den truncated toward zero, clipped to the element range.
    function automatic elem_t scaled_div(longint d, longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : d;
        q = (mag << FB) / den;
        if (d < 0)
            return (q > longint'(-MINN)) ? elem_t'(MINN) : elem_t'(-longint'(q));
        return (q > MAXP) ? elem_t'(MAXP) : elem_t'(q);
    endfunction

    // Expected quaternion for one matrix.
    function automatic quat_t quat_of_matrix(longint m[3][3]);
        quat_t res;
        longint tr, arg;
        longint unsigned root, den;
        elem_t part[4];
        int i, j, k;
        part = '{default: '0};
        res.bad = 1'b0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            root = isqrt(longint'(tr + ONE) << FB);
            den = root << 1;
            res.br = BR_TRACE;
            part[SLOT_W] = elem_t'(root >> 1);
            part[SLOT_X] = scaled_div(m[1][2] - m[2][1], den);
            part[SLOT_Y] = scaled_div(m[2][0] - m[0][2], den);
            part[SLOT_Z] = scaled_div(m[0][1] - m[1][0], den);
        end
        else
        begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            res.br = branch_t'(i + 1);
            arg = m[i][i] - (m[j][j] + m[k][k]) + ONE;
            if (arg < 0)
            begin
                arg = 0;
                res.bad = 1'b1;
            end
            root = isqrt(longint'(arg) << FB);
            part[i] = elem_t'(root >> 1);
            if (root != 0)
            begin
                den = root << 1;
                part[SLOT_W] = scaled_div(m[j][k] - m[k][j], den);
                part[j] = scaled_div(m[i][j] + m[j][i], den);
                part[k] = scaled_div(m[i][k] + m[k][i], den);
            end
        end
        res.qx = part[SLOT_X];
        res.qy = part[SLOT_Y];
        res.qz = part[SLOT_Z];
        res.qw = part[SLOT_W];
        return res;
    endfunction

    // Offer one matrix and hold it until the block takes it; predict on acceptance.
    task automatic send_matrix(longint m[3][3], bit allow_gap = 1'b1);
        while (allow_gap && ($urandom_range(99) < tx_idle_pct))
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        m00 <= elem_t'(m[0][0]); m01 <= elem_t'(m[0][1]); m02 <= elem_t'(m[0][2]);
        m10 <= elem_t'(m[1][0]); m11 <= elem_t'(m[1][1]); m12 <= elem_t'(m[1][2]);
        m20 <= elem_t'(m[2][0]); m21 <= elem_t'(m[2][1]); m22 <= elem_t'(m[2][2]);
        @(posedge clk);
        while (full)
            @(posedge clk);
        quat_fifo.push_back(quat_of_matrix(m));
        beats_in++;
    endtask

    task automatic go_quiet();
        push <= 1'b0;
        @(posedge clk);
    endtask

    function automatic longint rand_elem();
        return longint'(elem_t'($urandom));
    endfunction

    // Element between -spread and +spread, for well-conditioned test matrices.
    function automatic longint near_unit(int spread);
        longint v;
        v = longint'($urandom_range(2 * spread)) - spread;
        return v;
    endfunction

    // Field extremes and each branch, including diagonal ties and saturating lanes.
    task automatic test_directed();
        longint m[3][3];
        longint ext[4] = '{MINN, MAXP, 0, -1};
        m = '{'{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}};
        send_matrix(m);
        m = '{'{ONE, 0, 0}, '{0, -ONE, 0}, '{0, 0, -ONE}};
        send_matrix(m);
        m = '{'{-ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, -ONE}};
        send_matrix(m);
        m = '{'{-ONE, 0, 0}, '{0, -ONE, 0}, '{0, 0, ONE}};
        send_matrix(m);
        // Ties on the diagonal keep the lower index.
        m = '{'{-ONE, 0, 0}, '{0, -ONE, 0}, '{0, 0, -ONE}};
        send_matrix(m);
        // Extreme diagonal entries; then small diagonals with nonzero off-diagonals.
        m = '{'{MINN, 5, 7}, '{3, MAXP, 1}, '{2, 9, MAXP}};
        send_matrix(m);
        m = '{'{-ONE, 3, 4}, '{5, -ONE, 6}, '{7, 8, -ONE}};
        send_matrix(m);
        m = '{'{0, 3, 4}, '{5, 0, 6}, '{7, 8, -ONE}};
        send_matrix(m);
        // Huge differences over a small root saturate.
        m = '{'{1, MAXP, MINN}, '{MINN, 0, MAXP}, '{MAXP, MINN, 0}};
        send_matrix(m);
        m = '{'{MINN, MAXP, MAXP}, '{MAXP, MINN, MAXP}, '{MAXP, MAXP, MINN}};
        send_matrix(m);
        m = '{'{MAXP, MAXP, MAXP}, '{MAXP, MAXP, MAXP}, '{MAXP, MAXP, MAXP}};
        send_matrix(m);
        m = '{'{MINN, MINN, MINN}, '{MINN, MINN, MINN}, '{MINN, MINN, MINN}};
        send_matrix(m);
        for (int n = 0; n < 8; n++)
        begin
            foreach (m[a, b])
                m[a][b] = ext[$urandom_range(3)];
            send_matrix(m);
        end
        go_quiet();
    endtask

    // Random matrices: mostly near-rotations, the rest unrestricted.
    task automatic test_random(int count);
        longint m[3][3];
        int d;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 70)
            begin
                d = $urandom_range(2);
                foreach (m[a, b])
                    m[a][b] = near_unit(int'(ONE));
                if ($urandom_range(1))
                    m[d][d] = ONE - near_unit(int'(ONE / 8));
            end
            else
                foreach (m[a, b])
                    m[a][b] = rand_elem();
            send_matrix(m, n % 300 < 220);
        end
        go_quiet();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    // More beats are offered than the pipeline, queue and registers can hold.
    task automatic test_backpressure();
        longint m[3][3];
        rx_hold = 300;
        for (int n = 0; n < 100; n++)
        begin
            foreach (m[a, b])
                m[a][b] = rand_elem();
            send_matrix(m, 1'b0);
        end
        go_quiet();
    endtask

    task automatic wait_drained();
        while (quat_fifo.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random pops, with a stretch that never idles and an optional hold.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        quat_t exp_q;
        if (rst_n && pop && !empty)
        begin
            beats_out++;
            if (quat_fifo.size() == 0)
            begin
                $error("result beat with no prediction waiting");
                mismatches++;
            end
            else
            begin
                exp_q = quat_fifo.pop_front();
                branch_seen[exp_q.br]++;
                if (exp_q.bad) clamped_seen++;
                if (qx !== exp_q.qx)
                begin
                    $error("qx expected %0d actual %0d", exp_q.qx, qx); mismatches++;
                end
                if (qy !== exp_q.qy)
                begin
                    $error("qy expected %0d actual %0d", exp_q.qy, qy); mismatches++;
                end
                if (qz !== exp_q.qz)
                begin
                    $error("qz expected %0d actual %0d", exp_q.qz, qz); mismatches++;
                end
                if (qw !== exp_q.qw)
                begin
                    $error("qw expected %0d actual %0d", exp_q.qw, qw); mismatches++;
                end
                if (branch !== exp_q.br)
                begin
                    $error("branch expected %0d actual %0d", exp_q.br, branch);
                    mismatches++;
                end
                if (invalid !== exp_q.bad)
                begin
                    $error("invalid expected %0d actual %0d", exp_q.bad, invalid);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat accepted on either side and no receiver hold.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || rx_hold > 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_backpressure();
        // Sender pauses until every prediction has been met.
        wait_drained();
        test_random(500);
        rx_idle_pct = 0;
        tx_idle_pct = 0;
        test_random(200);
        rx_idle_pct = 24;
        tx_idle_pct = 24;
        test_random(330);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        $display("%0d matrices in, %0d results out; branches trace/x/y/z: %0d %0d %0d %0d",
                 beats_in, beats_out, branch_seen[0], branch_seen[1], branch_seen[2],
                 branch_seen[3]);
        $display("%0d clamped root arguments, with input stall and long result hold-off",
                 clamped_seen);
        if (mismatches == 0 && quat_fifo.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
